FILE: rtl/core/mfbp_pkg.sv
// Shared constants for the MSB-first bit packer.
// No dependencies; imported by mfbp_shift_unit and msb_first_bit_packer.
package mfbp_pkg;

  localparam int VALUE_W = 31;  // payload value bits
  localparam int BYTE_W  = 8;   // bits per output byte
  localparam int FILL_W  = 3;   // bits held in the partial byte, 0..7
  localparam int TAKE_W  = 4;   // bits moved in one step, 0..8

endpackage

FILE: rtl/core/mfbp_shift_unit.sv
// Shared shift unit: right-shifts the held value, tests for leftover bits,
// and merges a chunk into the partial byte. Depends on mfbp_pkg.
module mfbp_shift_unit #(
  parameter int RW = 6
) (
  input  logic [mfbp_pkg::VALUE_W-1:0] value_i,
  input  logic [RW-1:0]                amt_i,
  input  logic [mfbp_pkg::TAKE_W-1:0]  take_i,
  input  logic [mfbp_pkg::BYTE_W-1:0]  pending_i,
  input  logic [mfbp_pkg::FILL_W-1:0]  fill_i,
  output logic                         nonzero_o,
  output logic [mfbp_pkg::BYTE_W-1:0]  merged_o
);
  import mfbp_pkg::*;

  logic [VALUE_W-1:0] shifted;
  logic [BYTE_W-1:0]  mask;
  logic [BYTE_W-1:0]  chunk;
  logic [TAKE_W-1:0]  pos;

  always_comb begin
    shifted   = value_i >> amt_i;
    nonzero_o = |shifted;
    mask      = BYTE_W'(({{BYTE_W{1'b0}}, 1'b1} << take_i) - {{BYTE_W{1'b0}}, 1'b1});
    chunk     = shifted[BYTE_W-1:0] & mask;
    // chunk lands just below the bits already held
    pos       = TAKE_W'(BYTE_W) - {1'b0, fill_i} - take_i;
    merged_o  = pending_i | (chunk << pos);
  end

endmodule

FILE: rtl/core/msb_first_bit_packer.sv
// MSB-first bit packer. Each write request packs the low `width` bits of
// `value` (width saturated to MAX_WIDTH, bits above bit 30 packed as zero)
// into a byte stream, first bit into bit 7 of each byte; a value that needs
// more bits than the width gives one error result and packs nothing. A flush
// request emits the partial byte, zero padded, if it holds any bits, then
// clears it. Results carry last on the final result a request causes; a
// request may cause none. Timing: one request at a time. A write is accepted,
// checked for fit, then packed one chunk per step, each chunk filling the
// partial byte or finishing the value; a finished result waits while the
// output register is still held by out_stall. An error or flush result is
// made in the check step, with the same wait. The single shift/merge unit
// moves at most one byte's worth of bits per cycle, and none while a
// finished byte waits on out_stall. in_stall is high whenever a request is
// in progress.
// Depends on mfbp_pkg and mfbp_shift_unit.
module msb_first_bit_packer #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [mfbp_pkg::VALUE_W-1:0] in_value,
  input  logic [5:0]                   in_width,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mfbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_error,
  output logic                         out_last
);
  import mfbp_pkg::*;

  // bits remaining in a write, 0..MAX_WIDTH
  localparam int RW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PACK
  } state_t;

  state_t state_r, state_nxt;

  // request held while it is worked on
  logic               action_r, action_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;

  // partial byte
  logic [BYTE_W-1:0]  pending_r, pending_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_error_r, out_error_nxt;
  logic               out_last_r, out_last_nxt;

  logic [RW-1:0]      width_sat;
  logic [TAKE_W-1:0]  room;
  logic [TAKE_W-1:0]  take;
  logic [RW-1:0]      rem_after;
  logic [RW-1:0]      amt;
  logic               byte_done;
  logic               out_free;
  logic               nonzero;
  logic [BYTE_W-1:0]  merged;

  // width saturation: compare one bit wider so MAX_WIDTH = 64 still fits
  assign width_sat = ({1'b0, in_width} > 7'(MAX_WIDTH)) ? RW'(MAX_WIDTH) : RW'(in_width);

  // chunk size: fill the partial byte or finish the value, whichever is first
  assign room      = TAKE_W'(BYTE_W) - {1'b0, fill_r};
  assign take      = (rem_r < RW'(room)) ? TAKE_W'(rem_r) : room;
  assign rem_after = rem_r - RW'(take);
  assign byte_done = (({1'b0, fill_r} + take) == TAKE_W'(BYTE_W));

  // the check shifts by the full width, packing by what is left after this chunk
  assign amt = (state_r == ST_CHECK) ? rem_r : rem_after;

  assign out_free = !out_valid_r || !out_stall;

  mfbp_shift_unit #(
    .RW (RW)
  ) u_shift (
    .value_i   (value_r),
    .amt_i     (amt),
    .take_i    (take),
    .pending_i (pending_r),
    .fill_i    (fill_r),
    .nonzero_o (nonzero),
    .merged_o  (merged)
  );

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    value_nxt     = value_r;
    rem_nxt       = rem_r;
    pending_nxt   = pending_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_error_nxt = out_error_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          value_nxt  = in_value;
          rem_nxt    = width_sat;
          state_nxt  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (action_r) begin
          // flush: emit partial byte if any bits are held
          if (fill_r == '0) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = pending_r;
            out_error_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            pending_nxt   = '0;
            fill_nxt      = '0;
            state_nxt     = ST_IDLE;
          end
        end else if (nonzero) begin
          // value has bits above the width
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_error_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PACK;
        end
      end

      ST_PACK: begin
        // a completed byte waits for the output register
        if (!byte_done || out_free) begin
          rem_nxt = rem_after;
          if (byte_done) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = merged;
            out_error_nxt = 1'b0;
            // fewer than a byte's bits left: no further byte from this write
            out_last_nxt  = (rem_after < RW'(BYTE_W));
            pending_nxt   = '0;
            fill_nxt      = '0;
          end else begin
            pending_nxt = merged;
            fill_nxt    = FILL_W'({1'b0, fill_r} + take);
          end
          if (rem_after == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r    <= action_nxt;
    value_r     <= value_nxt;
    rem_r       <= rem_nxt;
    out_byte_r  <= out_byte_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

endmodule

FILE: verif/tb_msb_first_bit_packer.sv
`timescale 1ns / 1ps
// Self-checking testbench for msb_first_bit_packer: write and flush requests go in,
// packed bytes are checked against a bit-level predictor of the packing rules.
// Depends on mfbp_pkg and the msb_first_bit_packer RTL.
module tb_msb_first_bit_packer;
  import mfbp_pkg::*;

  localparam int  PACK_MAX_W   = 32;    // MAX_WIDTH of the instance
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;
  localparam int  HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int  STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int  DRAIN_CYCLES = 20;    // settle time after the last expected result
  localparam int  MAX_REPORTS  = 10;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              last;
  } packed_byte_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [VALUE_W-1:0] in_value;
  logic [5:0]         in_width;
  logic               out_valid;
  logic               out_stall;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_error;
  logic               out_last;

  // Predictor state: partial byte filled from bit 7 down, and its bit count.
  logic [BYTE_W-1:0]  pend_byte;
  int                 fill_cnt;
  packed_byte_t       expected_bytes[$];

  int  mismatches;
  int  idle_cycles;
  bit  quiet;      // no idling on either side
  bit  hold_req;   // ask the receiver for one long hold-off

  msb_first_bit_packer #(.MAX_WIDTH(PACK_MAX_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_value(in_value), .in_width(in_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_error(out_error), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes one accepted request should produce; last marks the final one.
  function automatic void predict_request(input logic act, input logic [VALUE_W-1:0] val,
                                          input logic [5:0] wid);
    int           eff_w;
    int           nbits;
    packed_byte_t res[$];
    packed_byte_t r;
    logic         bit_v;
    r.err  = 1'b0;
    r.last = 1'b0;
    if (act == ACT_FLUSH) begin
      // Partial byte goes out zero padded, only if it holds bits.
      if (fill_cnt != 0) begin
        r.data = pend_byte;
        res = {res, r};
      end
      pend_byte = '0;
      fill_cnt  = 0;
    end else begin
      eff_w = (int'(wid) > PACK_MAX_W) ? PACK_MAX_W : int'(wid);
      nbits = 0;
      for (int i = 0; i < VALUE_W; i++) if (val[i]) nbits = i + 1;
      if (nbits > eff_w) begin
        // Too wide for its field: one error, nothing packed.
        r.data = '0;
        r.err  = 1'b1;
        res = {res, r};
      end else begin
        for (int pos = eff_w - 1; pos >= 0; pos--) begin
          // Field positions above the value port pack as zero.
          bit_v = (pos < VALUE_W) ? val[pos] : 1'b0;
          pend_byte[7 - fill_cnt] = bit_v;
          fill_cnt++;
          if (fill_cnt == BYTE_W) begin
            r.data = pend_byte;
            res = {res, r};
            pend_byte = '0;
            fill_cnt  = 0;
          end
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    expected_bytes = {expected_bytes, res};
  endfunction

  // Random value of exactly len significant bits (0 gives zero).
  function automatic logic [VALUE_W-1:0] value_of_length(input int len);
    logic [31:0] v;
    if (len <= 0) return '0;
    v = $urandom & ((32'd1 << len) - 32'd1);
    v = v | (32'd1 << (len - 1));
    return v[VALUE_W-1:0];
  endfunction

  // Offer one request, with an optional idle burst first; returns once accepted.
  // Valid is left high so back-to-back requests need no extra NBA.
  task automatic send_request(input logic act, input logic [VALUE_W-1:0] val,
                              input logic [5:0] wid);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    in_width  <= wid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(act, val, wid);
  endtask

  // Random request mix: mostly fitting writes, some misfits and flushes,
  // now and then zero or oversized widths.
  task automatic send_random_request();
    int          kind;
    int          wsel;
    int          wid;
    int          eff_w;
    kind = $urandom_range(0, 99);
    wsel = $urandom_range(0, 19);
    wid  = (wsel == 0) ? 0 : (wsel == 1) ? $urandom_range(33, 63) : $urandom_range(1, 32);
    if (kind < 10) begin
      send_request(ACT_FLUSH, VALUE_W'($urandom), wid[5:0]);
    end else if (kind < 20) begin
      wid = $urandom_range(0, 30);
      send_request(ACT_WRITE, value_of_length($urandom_range(wid + 1, VALUE_W)), wid[5:0]);
    end else begin
      eff_w = (wid > PACK_MAX_W) ? PACK_MAX_W : wid;
      if (eff_w > VALUE_W) eff_w = VALUE_W;
      // Bias toward full-length values so high bits get exercised.
      send_request(ACT_WRITE,
                   value_of_length(($urandom_range(0, 2) == 0) ? eff_w
                                                               : $urandom_range(0, eff_w)),
                   wid[5:0]);
    end
  endtask

  task automatic test_field_extremes();
    send_request(ACT_WRITE, '0, 6'd1);
    send_request(ACT_WRITE, '1, 6'd31);
    send_request(ACT_WRITE, '1, 6'd32);       // leading zero above bit 30
    send_request(ACT_WRITE, '0, 6'd0);        // packs nothing
    send_request(ACT_WRITE, '1, 6'd63);       // saturates to MAX_WIDTH
    send_request(ACT_WRITE, 31'd1, 6'd33);
    send_request(ACT_WRITE, 31'h55, 6'd8);
    send_request(ACT_FLUSH, '0, 6'd0);
  endtask

  task automatic test_fit_errors();
    send_request(ACT_WRITE, 31'd1, 6'd0);     // zero width, nonzero value
    send_request(ACT_WRITE, 31'd8, 6'd3);
    send_request(ACT_WRITE, 31'd7, 6'd3);     // just fits
    send_request(ACT_WRITE, '1, 6'd30);
    send_request(ACT_WRITE, 31'h4000_0000, 6'd31);
    send_request(ACT_FLUSH, '0, 6'd1);
  endtask

  task automatic test_flush_rules();
    send_request(ACT_FLUSH, '0, 6'd0);        // nothing pending
    send_request(ACT_FLUSH, '1, 6'd63);
    send_request(ACT_WRITE, 31'd1, 6'd1);
    send_request(ACT_FLUSH, VALUE_W'($urandom), 6'd17); // value ignored on flush
    send_request(ACT_WRITE, 31'd3, 6'd7);     // seven bits pending
    send_request(ACT_FLUSH, '1, 6'd32);
  endtask

  task automatic test_random_stream(input int n);
    for (int i = 0; i < n; i++) send_random_request();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // packer backs up into in_stall.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_request(ACT_WRITE, value_of_length($urandom_range(24, VALUE_W)), 6'd32);
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_steady_tail(input int n);
    quiet = 1'b1;
    for (int i = 0; i < n; i++) send_random_request();
  endtask

  task automatic note_mismatch(input string what, input packed_byte_t want,
                               input packed_byte_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected byte %02h err %0b last %0b, got byte %02h err %0b last %0b",
               $realtime, what, want.data, want.err, want.last, got.data, got.err, got.last);
  endtask

  // Receiver pacing: random stall bursts, one long hold-off on request.
  initial begin : output_pacing
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_bytes
    packed_byte_t got;
    packed_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.data = out_byte;
      got.err  = out_error;
      got.last = out_last;
      if (expected_bytes.size() == 0) begin
        want = '{data: '0, err: 1'b0, last: 1'b0};
        note_mismatch("unexpected result", want, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.err !== want.err || got.last !== want.last)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: too long with no transfer on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, expected_bytes.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pend_byte   = '0;
    fill_cnt    = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_action <= ACT_WRITE;
    in_value  <= '0;
    in_width  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_fit_errors();
    test_flush_rules();
    test_random_stream(320);
    test_backpressure();
    test_steady_tail(50);

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mfbp_pkg.sv
rtl/core/mfbp_shift_unit.sv
rtl/core/msb_first_bit_packer.sv
verif/tb_msb_first_bit_packer.sv
